>>> rtl/ske_pkg.sv
// Shared types, constants and helpers for the SPH kernel evaluator.
`timescale 1ns / 1ps
package ske_pkg;

  // Fixed point fraction bits of positions, radius and results.
  localparam int FRAC_BITS = 16;

  // Stage counts of the gradient datapath.
  localparam int SQRT_STAGES = 16;  // 31 root bits, two per stage
  localparam int MID_STAGES  = 8;   // product chain and divider setup
  localparam int DIV_STAGES  = 9;   // 34 quotient bits, four per stage
  localparam int GRAD_LAT    = SQRT_STAGES + MID_STAGES + DIV_STAGES + 1;
  localparam int POST_LEN    = MID_STAGES + DIV_STAGES;
  localparam int QUO_W       = 34;
  localparam int DIV_STEPS   = 4;

  // Stage count of the poly6 product and scaling chain.
  localparam int POLY_LAT = 9;

  typedef enum logic [1:0] {
    FUNC_POLY6 = 2'd0,
    FUNC_SPIKY = 2'd1,
    FUNC_SCORR = 2'd2,
    FUNC_NONE  = 2'd3
  } ske_func_e;

  typedef enum logic [2:0] {
    REG_RADIUS     = 3'd0,
    REG_TENSILE_SQ = 3'd1,
    REG_POLY_MANT  = 3'd2,
    REG_POLY_EXP   = 3'd3,
    REG_SPIKY_MANT = 3'd4,
    REG_SPIKY_EXP  = 3'd5
  } ske_reg_e;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] pos_i_x;
    logic signed [31:0] pos_i_y;
    logic signed [31:0] pos_i_z;
    logic signed [31:0] pos_j_x;
    logic signed [31:0] pos_j_y;
    logic signed [31:0] pos_j_z;
  } ske_in_t;

  typedef struct packed {
    logic signed [31:0] weight;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic               saturated;
  } ske_out_t;

  typedef struct packed {
    logic [30:0]       radius;
    logic [30:0]       tensile_ref_sq;
    logic [31:0]       poly_coef_mant;
    logic signed [6:0] poly_coef_exp;
    logic [31:0]       spiky_coef_mant;
    logic signed [6:0] spiky_coef_exp;
  } ske_cfg_t;

  localparam ske_cfg_t CFG_RESET = '{
    radius:          31'd65536,
    tensile_ref_sq:  31'd6554,
    poly_coef_mant:  32'd1682212077,
    poly_coef_exp:   -7'sd30,
    spiky_coef_mant: 32'd1922526682,
    spiky_coef_exp:  -7'sd27
  };

  // Front end to gradient unit: distances and the poly6 base.
  typedef struct packed {
    logic             grad_en;
    logic [2:0][30:0] ad;
    logic [2:0]       dpos;
    logic [61:0]      r2;
    logic [61:0]      pmag;
    logic             pneg;
  } ske_pair_t;

  // Gradient unit to poly6 unit: finished gradient plus the poly6 base.
  typedef struct packed {
    logic [61:0]      pmag;
    logic             pneg;
    logic [2:0][31:0] grad;
    logic             gsat;
  } ske_grad_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } ske_res_t;

  // Round a value that carries one extra fraction bit half up, clamp and sign it.
  function automatic ske_res_t round_clamp(logic over, logic [QUO_W-1:0] q, logic neg);
    logic [QUO_W:0]   sum;
    logic [QUO_W-1:0] mag;
    logic [QUO_W-1:0] lim;
    ske_res_t         res;
    sum = {1'b0, q} + (QUO_W+1)'(1);
    mag = sum[QUO_W:1];
    lim = neg ? QUO_W'(33'h0_8000_0000) : QUO_W'(33'h0_7FFF_FFFF);
    res.sat = over || (mag > lim);
    if (res.sat) begin
      mag = lim;
    end
    res.val = neg ? (32'd0 - mag[31:0]) : mag[31:0];
    return res;
  endfunction

endpackage

>>> rtl/ske_front.sv
// Front end: coordinate differences, squared distance and kernel selection.
`timescale 1ns / 1ps
module ske_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  ske_pkg::ske_in_t    data_i,
  input  ske_pkg::ske_cfg_t   cfg_i,
  output logic                valid_o,
  output ske_pkg::ske_pair_t  pair_o
);

  logic [3:0] v_q;

  ske_pkg::ske_func_e func1_q, func2_q, func3_q;
  logic               far1_q, far2_q, far3_q;
  logic [2:0][30:0]   ad1_q, ad2_q, ad3_q;
  logic [2:0]         dpos1_q, dpos2_q, dpos3_q;
  logic [61:0]        hsq1_q, hsq2_q, hsq3_q;
  logic [2:0][61:0]   sq2_q;
  logic [61:0]        bmag2_q, bmag3_q;
  logic               bneg2_q, bneg3_q;
  logic [63:0]        r2_3_q;

  logic [2:0][31:0]   pi, pj;
  logic [2:0][30:0]   ad1_d;
  logic [2:0]         dpos1_d;
  logic               far1_d;
  logic [61:0]        tb;
  ske_pkg::ske_pair_t pair_d;

  assign pi = {data_i.pos_i_z, data_i.pos_i_y, data_i.pos_i_x};
  assign pj = {data_i.pos_j_z, data_i.pos_j_y, data_i.pos_j_x};

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  // Stage 1: exact differences, magnitudes and the far test.
  always_comb begin
    logic [32:0] d;
    logic [32:0] ad;
    far1_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      d = {pi[k][31], pi[k]} - {pj[k][31], pj[k]};
      ad = d[32] ? (33'd0 - d) : d;
      if (ad >= {2'b00, cfg_i.radius}) begin
        far1_d = 1'b1;
      end
      ad1_d[k] = ad[30:0];
      dpos1_d[k] = !d[32] && (d != 33'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      func1_q <= ske_pkg::ske_func_e'(data_i.func);
      far1_q  <= far1_d;
      ad1_q   <= ad1_d;
      dpos1_q <= dpos1_d;
      hsq1_q  <= 62'(cfg_i.radius) * 62'(cfg_i.radius);
    end
  end

  // Stage 2: squares of the components and the scorr base.
  assign tb = 62'(cfg_i.tensile_ref_sq) << ske_pkg::FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      func2_q <= func1_q;
      far2_q  <= far1_q;
      ad2_q   <= ad1_q;
      dpos2_q <= dpos1_q;
      hsq2_q  <= hsq1_q;
      for (int k = 0; k < 3; k++) begin
        sq2_q[k] <= 62'(ad1_q[k]) * 62'(ad1_q[k]);
      end
      bneg2_q <= hsq1_q < tb;
      bmag2_q <= (hsq1_q < tb) ? (tb - hsq1_q) : (hsq1_q - tb);
    end
  end

  // Stage 3: squared distance.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      func3_q <= func2_q;
      far3_q  <= far2_q;
      ad3_q   <= ad2_q;
      dpos3_q <= dpos2_q;
      hsq3_q  <= hsq2_q;
      bmag3_q <= bmag2_q;
      bneg3_q <= bneg2_q;
      r2_3_q  <= 64'(sq2_q[0]) + 64'(sq2_q[1]) + 64'(sq2_q[2]);
    end
  end

  // Stage 4: radius test and choice of the poly6 base.
  always_comb begin
    logic in_range;
    in_range = !far3_q && (r2_3_q < 64'(hsq3_q));
    pair_d.ad   = ad3_q;
    pair_d.dpos = dpos3_q;
    pair_d.r2   = r2_3_q[61:0];
    pair_d.grad_en = 1'b0;
    pair_d.pmag = '0;
    pair_d.pneg = 1'b0;
    unique case (func3_q)
      ske_pkg::FUNC_POLY6: begin
        if (in_range) begin
          pair_d.pmag = hsq3_q - r2_3_q[61:0];
        end
      end
      ske_pkg::FUNC_SPIKY: pair_d.grad_en = in_range;
      ske_pkg::FUNC_SCORR: begin
        pair_d.pmag = bmag3_q;
        pair_d.pneg = bneg3_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pair_o <= pair_d;
    end
  end

  assign valid_o = v_q[3];

endmodule

>>> rtl/ske_grad.sv
// Spiky gradient datapath: square root, product chain and long division.
`timescale 1ns / 1ps
module ske_grad (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  ske_pkg::ske_pair_t  pair_i,
  input  ske_pkg::ske_cfg_t   cfg_i,
  output logic                valid_o,
  output ske_pkg::ske_grad_t  grad_o
);

  typedef struct packed {
    logic [63:0]        rem;
    logic [30:0]        root;
    ske_pkg::ske_pair_t p;
  } sq_t;

  typedef struct packed {
    ske_pkg::ske_pair_t p;
    logic [30:0]        r;
    logic               rz;
  } post_t;

  typedef struct packed {
    logic [30:0]               rem;
    logic [ske_pkg::QUO_W-1:0] lo;
    logic [ske_pkg::QUO_W-1:0] quo;
    logic                      over;
  } div_t;

  logic [ske_pkg::GRAD_LAT-1:0] v_q;

  sq_t              sq_q [ske_pkg::SQRT_STAGES];
  post_t            ps_q [ske_pkg::POST_LEN];
  logic [30:0]      q1_q;
  logic [61:0]      q2_q;
  logic [63:0]      pa_q;
  logic [61:0]      pb_q;
  logic [93:0]      qm_q;
  logic [2:0][62:0] m0_q, m1_q;
  logic [2:0][60:0] m2_q;
  logic [2:0][124:0] n_q;
  logic [2:0][156:0] dd_q;
  div_t [2:0]       d0_q;
  div_t [2:0]       dv_q [ske_pkg::DIV_STAGES];

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[ske_pkg::GRAD_LAT-2:0], valid_i};
    end
  end

  // Floor square root of r2, two result bits per stage.
  for (genvar k = 0; k < ske_pkg::SQRT_STAGES; k++) begin : g_sqrt
    sq_t cur, nxt;
    if (k == 0) begin : g_first
      always_comb begin
        cur.rem  = {2'b00, pair_i.r2};
        cur.root = '0;
        cur.p    = pair_i;
      end
    end else begin : g_next
      assign cur = sq_q[k-1];
    end

    always_comb begin
      logic [63:0] trial;
      int          bi;
      nxt = cur;
      trial = '0;
      for (int j = 0; j < 2; j++) begin
        bi = 30 - 2 * k - j;
        if (bi >= 0) begin
          trial = (64'(nxt.root) << (bi + 1)) + (64'd1 << (2 * bi));
          if (nxt.rem >= trial) begin
            nxt.rem  = nxt.rem - trial;
            nxt.root = nxt.root | (31'd1 << bi);
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[k] <= nxt;
      end
    end
  end

  // Side data chain after the square root.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ps_q[0].p  <= sq_q[ske_pkg::SQRT_STAGES-1].p;
      ps_q[0].r  <= sq_q[ske_pkg::SQRT_STAGES-1].root;
      ps_q[0].rz <= sq_q[ske_pkg::SQRT_STAGES-1].root == 31'd0;
      for (int s = 1; s < ske_pkg::POST_LEN; s++) begin
        ps_q[s] <= ps_q[s-1];
      end
    end
  end

  // Product chain: (h - r)^2 * kspiky mantissa * |d|.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q1_q <= cfg_i.radius - sq_q[ske_pkg::SQRT_STAGES-1].root;
      q2_q <= 62'(q1_q) * 62'(q1_q);
      pa_q <= 64'(q2_q[31:0]) * 64'(cfg_i.spiky_coef_mant);
      pb_q <= 62'(q2_q[61:32]) * 62'(cfg_i.spiky_coef_mant);
      qm_q <= 94'(pa_q) + (94'(pb_q) << 32);
      for (int l = 0; l < 3; l++) begin
        m0_q[l] <= 63'(qm_q[31:0]) * 63'(ps_q[3].p.ad[l]);
        m1_q[l] <= 63'(qm_q[63:32]) * 63'(ps_q[3].p.ad[l]);
        m2_q[l] <= 61'(qm_q[93:64]) * 61'(ps_q[3].p.ad[l]);
        n_q[l]  <= 125'(m0_q[l]) + (125'(m1_q[l]) << 32) + (125'(m2_q[l]) << 64);
      end
    end
  end

  // Scale by 2^(exponent - 2*FRAC_BITS + 1); the extra bit feeds the rounding.
  always_ff @(posedge clk_i) begin
    int sh;
    sh = int'(cfg_i.spiky_coef_exp) - 2 * ske_pkg::FRAC_BITS + 1;
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        if (sh >= 0) begin
          dd_q[l] <= 157'(n_q[l]) << sh;
        end else begin
          dd_q[l] <= 157'(n_q[l]) >> (-sh);
        end
      end
    end
  end

  // Divider setup: overflow test of the upper dividend against r.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        d0_q[l].over <= (|dd_q[l][156:65]) || (dd_q[l][64:34] >= ps_q[6].r);
        d0_q[l].rem  <= dd_q[l][64:34];
        d0_q[l].lo   <= dd_q[l][33:0];
        d0_q[l].quo  <= '0;
      end
    end
  end

  // Restoring division by r, four quotient bits per stage.
  for (genvar k = 0; k < ske_pkg::DIV_STAGES; k++) begin : g_div
    div_t [2:0]  cur, nxt;
    logic [30:0] rv;
    if (k == 0) begin : g_first
      assign cur = d0_q;
    end else begin : g_next
      assign cur = dv_q[k-1];
    end
    assign rv = ps_q[ske_pkg::MID_STAGES-1+k].r;

    always_comb begin
      logic [31:0] t;
      nxt = cur;
      t = '0;
      for (int l = 0; l < 3; l++) begin
        for (int j = 0; j < ske_pkg::DIV_STEPS; j++) begin
          if (k * ske_pkg::DIV_STEPS + j < ske_pkg::QUO_W) begin
            t = {nxt[l].rem, nxt[l].lo[ske_pkg::QUO_W-1]};
            nxt[l].lo = nxt[l].lo << 1;
            if (t >= {1'b0, rv}) begin
              t = t - {1'b0, rv};
              nxt[l].quo = {nxt[l].quo[ske_pkg::QUO_W-2:0], 1'b1};
            end else begin
              nxt[l].quo = {nxt[l].quo[ske_pkg::QUO_W-2:0], 1'b0};
            end
            nxt[l].rem = t[30:0];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[k] <= nxt;
      end
    end
  end

  // Final rounding, clamping and gating of the gradient.
  always_ff @(posedge clk_i) begin
    ske_pkg::ske_res_t res;
    post_t             ps;
    logic              gate;
    logic              gsat;
    ps = ps_q[ske_pkg::POST_LEN-1];
    gate = ps.p.grad_en && !ps.rz;
    gsat = 1'b0;
    if (en_i) begin
      grad_o.pmag <= ps.p.pmag;
      grad_o.pneg <= ps.p.pneg;
      for (int l = 0; l < 3; l++) begin
        res = ske_pkg::round_clamp(dv_q[ske_pkg::DIV_STAGES-1][l].over,
                                   dv_q[ske_pkg::DIV_STAGES-1][l].quo, ps.p.dpos[l]);
        grad_o.grad[l] <= gate ? res.val : 32'd0;
        gsat = gsat || (gate && res.sat);
      end
      grad_o.gsat <= gsat;
    end
  end

  assign valid_o = v_q[ske_pkg::GRAD_LAT-1];

endmodule

>>> rtl/ske_poly.sv
// Poly6 datapath: exact cube times coefficient, scaling and result assembly.
`timescale 1ns / 1ps
module ske_poly (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  ske_pkg::ske_grad_t  grad_i,
  input  ske_pkg::ske_cfg_t   cfg_i,
  output logic                valid_o,
  output ske_pkg::ske_out_t   data_o
);

  logic [ske_pkg::POLY_LAT-1:0] v_q;

  ske_pkg::ske_grad_t gq_q [ske_pkg::POLY_LAT-1];
  logic [63:0]        pp00_q;
  logic [61:0]        pp01_q;
  logic [59:0]        pp11_q;
  logic [123:0]       m2_q;
  logic [3:0][63:0]   c_q;
  logic [155:0]       m3_q;
  logic [4:0][63:0]   e0_q;
  logic [4:0][61:0]   e1_q;
  logic [187:0]       s0_q;
  logic [185:0]       s1_q;
  logic [217:0]       p_q;
  logic [33:0]        r34_q;
  logic               rov_q;

  logic [127:0]       m2x;
  logic [159:0]       m3x;
  logic [187:0]       s0_d;
  logic [185:0]       s1_d;
  logic [155:0]       m3_d;
  logic [217:0]       rs;
  logic [7:0]         shr;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[ske_pkg::POLY_LAT-2:0], valid_i};
    end
  end

  // Gradient results ride along.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gq_q[0] <= grad_i;
      for (int s = 1; s < ske_pkg::POLY_LAT - 1; s++) begin
        gq_q[s] <= gq_q[s-1];
      end
    end
  end

  assign m2x = {4'b0, m2_q};
  assign m3x = {4'b0, m3_q};

  // Partial product sums.
  always_comb begin
    m3_d = '0;
    for (int l = 0; l < 4; l++) begin
      m3_d = m3_d + (156'(c_q[l]) << (32 * l));
    end
    s0_d = '0;
    s1_d = '0;
    for (int l = 0; l < 5; l++) begin
      s0_d = s0_d + (188'(e0_q[l]) << (32 * l));
      s1_d = s1_d + (186'(e1_q[l]) << (32 * l));
    end
  end

  // Base squared, times the mantissa, times the base again.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp00_q <= 64'(grad_i.pmag[31:0]) * 64'(grad_i.pmag[31:0]);
      pp01_q <= 62'(grad_i.pmag[31:0]) * 62'(grad_i.pmag[61:32]);
      pp11_q <= 60'(grad_i.pmag[61:32]) * 60'(grad_i.pmag[61:32]);
      m2_q   <= 124'(pp00_q) + (124'(pp01_q) << 33) + (124'(pp11_q) << 64);
      for (int l = 0; l < 4; l++) begin
        c_q[l] <= 64'(m2x[32*l +: 32]) * 64'(cfg_i.poly_coef_mant);
      end
      m3_q <= m3_d;
      for (int l = 0; l < 5; l++) begin
        e0_q[l] <= 64'(m3x[32*l +: 32]) * 64'(gq_q[3].pmag[31:0]);
        e1_q[l] <= 62'(m3x[32*l +: 32]) * 62'(gq_q[3].pmag[61:32]);
      end
      s0_q <= s0_d;
      s1_q <= s1_d;
      p_q  <= 218'(s0_q) + (218'(s1_q) << 32);
    end
  end

  // Scale by two to the (exponent - 5*FRAC_BITS), keeping one extra bit for rounding.
  assign shr = 8'(5 * ske_pkg::FRAC_BITS - 1 - int'(cfg_i.poly_coef_exp));
  assign rs  = p_q >> shr;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r34_q <= rs[33:0];
      rov_q <= |rs[217:34];
    end
  end

  // Output register: weight and gradient of one beat.
  always_ff @(posedge clk_i) begin
    ske_pkg::ske_res_t res;
    ske_pkg::ske_grad_t g;
    g = gq_q[ske_pkg::POLY_LAT-2];
    res = ske_pkg::round_clamp(rov_q, r34_q, g.pneg);
    if (en_i) begin
      data_o.weight    <= res.val;
      data_o.grad_x    <= g.grad[0];
      data_o.grad_y    <= g.grad[1];
      data_o.grad_z    <= g.grad[2];
      data_o.saturated <= res.sat || g.gsat;
    end
  end

  assign valid_o = v_q[ske_pkg::POLY_LAT-1];

endmodule

>>> rtl/sph_kernel_eval_unit.sv
// Top level of the SPH kernel evaluator: configuration registers and pipeline.
//
//   channel  direction  handshake             beat
//   in       input      in_valid_i/in_stall_o  ske_in_t   (func, two positions)
//   out      output     out_valid_o/out_stall_i ske_out_t (weight, gradient, flag)
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// One beat is accepted per cycle unless the output stalls; each result passes
// through the 16-stage square root and the 9-stage divider of the gradient path.
// Reset clears the valid bits and loads the default coefficients.
// A stalled output beat freezes the whole pipeline, and the input stalls with it.
`timescale 1ns / 1ps
module sph_kernel_eval_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ske_pkg::ske_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ske_pkg::ske_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i
);

  ske_pkg::ske_cfg_t  cfg_q;
  ske_pkg::ske_pair_t pair;
  ske_pkg::ske_grad_t grad;
  logic               en, pair_valid, grad_valid;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ske_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (ske_pkg::ske_reg_e'(cfg_idx_i))
        ske_pkg::REG_RADIUS:     cfg_q.radius          <= cfg_data_i[30:0];
        ske_pkg::REG_TENSILE_SQ: cfg_q.tensile_ref_sq  <= cfg_data_i[30:0];
        ske_pkg::REG_POLY_MANT:  cfg_q.poly_coef_mant  <= cfg_data_i;
        ske_pkg::REG_POLY_EXP:   cfg_q.poly_coef_exp   <= cfg_data_i[6:0];
        ske_pkg::REG_SPIKY_MANT: cfg_q.spiky_coef_mant <= cfg_data_i;
        ske_pkg::REG_SPIKY_EXP:  cfg_q.spiky_coef_exp  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a finished beat is held at the output.
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  ske_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cfg_i   (cfg_q),
    .valid_o (pair_valid),
    .pair_o  (pair)
  );

  ske_grad u_grad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pair_valid),
    .pair_i  (pair),
    .cfg_i   (cfg_q),
    .valid_o (grad_valid),
    .grad_o  (grad)
  );

  ske_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (grad_valid),
    .grad_i  (grad),
    .cfg_i   (cfg_q),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule
